FILE: src/icsum_pkg.sv
// Shared types, constants and ones'-complement helpers for the IPv6 checksum engine.
// No dependencies; every module in src imports this package.
package icsum_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_PREFIX = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_IID    = 8'd1;

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);

  // Result queue in the back part
  localparam int unsigned RES_DEPTH = 2;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  // Raw (unfolded) sum widths
  localparam int unsigned QUAD_SUM_W = 18;  // four 16-bit words
  localparam int unsigned CFG_SUM_W  = 19;  // eight 16-bit words
  localparam int unsigned PN_SUM_W   = 9;   // two 8-bit values
  localparam int unsigned HDR_SUM_W  = 21;  // whole pseudo header

  // One classified byte handed from front to back
  typedef struct packed {
    logic [7:0]  data_val;   // already forced to zero inside the checksum field
    logic        first_byte;
    logic        last_byte;
    logic [15:0] hdr_sum;    // folded pseudo-header sum, meaningful on a first byte
  } front_item_t;

  // Sum the four big-endian 16-bit words of a 64-bit value without folding.
  function automatic logic [QUAD_SUM_W-1:0] sum4(input logic [63:0] v);
    logic [QUAD_SUM_W-1:0] a;
    logic [QUAD_SUM_W-1:0] b;
    a = QUAD_SUM_W'(v[63:48]) + QUAD_SUM_W'(v[47:32]);
    b = QUAD_SUM_W'(v[31:16]) + QUAD_SUM_W'(v[15:0]);
    return a + b;
  endfunction

  // Fold a raw header sum into 16 bits with end-around carries.
  // A nonzero sum never folds to zero, matching a chain of ones'-complement adds.
  function automatic logic [15:0] fold_hdr(input logic [HDR_SUM_W-1:0] t);
    logic [16:0] f1;
    logic [16:0] f2;
    f1 = 17'(t[15:0]) + 17'(t[HDR_SUM_W-1:16]);
    f2 = 17'(f1[15:0]) + 17'(f1[16]);
    return f2[15:0];
  endfunction

  // 16-bit ones'-complement add
  function automatic logic [15:0] oc_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    logic [16:0] f;
    s = {1'b0, a} + {1'b0, b};
    f = 17'(s[15:0]) + 17'(s[16]);
    return f[15:0];
  endfunction

endpackage

FILE: src/ipv6_udp_checksum_engine_core.sv
// Top level of the IPv6 transport checksum engine.
// Instantiates icsum_front, icsum_queue and icsum_back; depends on icsum_pkg.
//
// Takes one payload byte per clock and returns the complemented 16-bit
// ones'-complement checksum over the IPv6 pseudo header (own prefix and
// interface identifier from registers 0 and 1, then destination, length and
// next header sampled with the first byte) and the payload. A byte is taken
// every cycle while the consumer keeps popping; in_full rises only when the
// four-entry queue between the header-sum pipeline and the accumulator, plus
// the two bytes in that pipeline, would run out of room. After a packet's last
// byte is accepted, its checksum passes both pipeline stages and the byte queue,
// enters the two-entry result queue once it has room and waits there for out_checksum
// until popped. Write the registers only while no packet is in progress;
// cfg_ready is always high and indexes other than 0 and 1 are ignored.
module ipv6_udp_checksum_engine_core import icsum_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic                 in_last_byte,
  input  logic                 in_zero_byte,
  input  logic [63:0]          in_dest_high,
  input  logic [63:0]          in_dest_low,
  input  logic [7:0]           in_packet_length,
  input  logic [7:0]           in_next_header,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [15:0]          out_checksum,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  logic              q_push;
  front_item_t       q_push_item;
  logic              q_pop;
  logic              q_head_valid;
  front_item_t       q_head_item;
  logic [QCNT_W-1:0] q_count;

  icsum_front u_front (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_push          (in_push),
    .in_full          (in_full),
    .in_data_byte     (in_data_byte),
    .in_first_byte    (in_first_byte),
    .in_last_byte     (in_last_byte),
    .in_zero_byte     (in_zero_byte),
    .in_dest_high     (in_dest_high),
    .in_dest_low      (in_dest_low),
    .in_packet_length (in_packet_length),
    .in_next_header   (in_next_header),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .q_count          (q_count),
    .q_push           (q_push),
    .q_item           (q_push_item)
  );

  icsum_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .count      (q_count)
  );

  icsum_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (q_head_valid),
    .q_item       (q_head_item),
    .q_pop        (q_pop),
    .out_empty    (out_empty),
    .out_pop      (out_pop),
    .out_checksum (out_checksum)
  );

endmodule

FILE: src/icsum_front.sv
// Front part: configuration registers, input acceptance and the two-stage
// pseudo-header sum pipeline. Depends on icsum_pkg.
module icsum_front import icsum_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic                 in_last_byte,
  input  logic                 in_zero_byte,
  input  logic [63:0]          in_dest_high,
  input  logic [63:0]          in_dest_low,
  input  logic [7:0]           in_packet_length,
  input  logic [7:0]           in_next_header,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  input  logic [QCNT_W-1:0]    q_count,
  output logic                 q_push,
  output front_item_t          q_item
);

  logic [63:0]           prefix_r;
  logic [63:0]           iid_r;
  logic [CFG_SUM_W-1:0]  cfg_sum_r;

  logic                  v1_r;
  logic [7:0]            data1_r;
  logic                  first1_r;
  logic                  last1_r;
  logic [QUAD_SUM_W-1:0] dh_sum1_r;
  logic [QUAD_SUM_W-1:0] dl_sum1_r;
  logic [PN_SUM_W-1:0]   pn1_r;

  logic                  v2_r;
  logic [7:0]            data2_r;
  logic                  first2_r;
  logic                  last2_r;
  logic [HDR_SUM_W-1:0]  total2_r;

  logic [QCNT_W-1:0]     occupancy;
  logic                  accept;

  assign cfg_ready = 1'b1;

  // Queue entries plus items still in the pipeline must leave room for one more
  assign occupancy = q_count + QCNT_W'(v1_r) + QCNT_W'(v2_r);
  assign in_full   = (occupancy >= QCNT_W'(QDEPTH));
  assign accept    = in_push && !in_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prefix_r  <= '0;
      iid_r     <= '0;
      cfg_sum_r <= '0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_SOURCE_PREFIX: prefix_r <= cfg_data;
          REG_SOURCE_IID:    iid_r    <= cfg_data;
          default: ;
        endcase
      end
      cfg_sum_r <= CFG_SUM_W'(sum4(prefix_r)) + CFG_SUM_W'(sum4(iid_r));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= accept;
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      data1_r   <= in_zero_byte ? 8'h00 : in_data_byte;
      first1_r  <= in_first_byte;
      last1_r   <= in_last_byte;
      dh_sum1_r <= sum4(in_dest_high);
      dl_sum1_r <= sum4(in_dest_low);
      pn1_r     <= PN_SUM_W'(in_packet_length) + PN_SUM_W'(in_next_header);
    end
    if (v1_r) begin
      data2_r  <= data1_r;
      first2_r <= first1_r;
      last2_r  <= last1_r;
      total2_r <= HDR_SUM_W'(cfg_sum_r) + HDR_SUM_W'(dh_sum1_r)
                + HDR_SUM_W'(dl_sum1_r) + HDR_SUM_W'(pn1_r);
    end
  end

  assign q_push              = v2_r;
  assign q_item.data_val     = data2_r;
  assign q_item.first_byte   = first2_r;
  assign q_item.last_byte    = last2_r;
  assign q_item.hdr_sum      = fold_hdr(total2_r);

  a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occupancy <= QCNT_W'(QDEPTH + 1) && q_count <= QCNT_W'(QDEPTH))
    else $error("front: items in flight exceed queue room");

endmodule

FILE: src/icsum_queue.sv
// Short queue of classified bytes between the front and back parts.
// Depends on icsum_pkg for the item type and depth.
module icsum_queue import icsum_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  front_item_t       push_item,
  input  logic              pop,
  output logic              head_valid,
  output front_item_t       head_item,
  output logic [QCNT_W-1:0] count
);

  front_item_t       entries_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] count_r;

  assign head_valid = (count_r != '0);
  assign head_item  = entries_r[rd_ptr_r];
  assign count      = count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      if (push && !pop)      count_r <= count_r + 1'b1;
      else if (pop && !push) count_r <= count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_item;
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |-> (count_r != QCNT_W'(QDEPTH)))
    else $error("queue: push into a full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue: pop from an empty queue");

endmodule

FILE: src/icsum_back.sv
// Back part: byte pairing, running ones'-complement sum and the result queue.
// Depends on icsum_pkg for the item type and oc_add.
module icsum_back import icsum_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_valid,
  input  front_item_t q_item,
  output logic        q_pop,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_checksum
);

  logic [15:0]          sum_r;
  logic [15:0]          sum_nxt;
  logic [7:0]           held_r;
  logic [7:0]           held_nxt;
  logic                 odd_r;
  logic                 odd_nxt;

  logic [15:0]          res_mem_r [RES_DEPTH];
  logic [RES_PTR_W-1:0] res_wr_r;
  logic [RES_PTR_W-1:0] res_rd_r;
  logic [RES_CNT_W-1:0] res_count_r;

  logic        out_take;
  logic        res_push;
  logic        take;
  logic [15:0] sum_base;
  logic [7:0]  held_base;
  logic        odd_base;
  logic [15:0] word;
  logic        do_add;
  logic [15:0] sum_acc;

  assign out_empty    = (res_count_r == '0);
  assign out_checksum = res_mem_r[res_rd_r];
  assign out_take     = out_pop && !out_empty;

  // Hold a last byte while the result queue has no room
  assign take     = q_valid && (!q_item.last_byte
                    || res_count_r != RES_CNT_W'(RES_DEPTH) || out_take);
  assign q_pop    = take;
  assign res_push = take && q_item.last_byte;

  always_comb begin
    sum_base  = q_item.first_byte ? q_item.hdr_sum : sum_r;
    held_base = q_item.first_byte ? 8'h00 : held_r;
    odd_base  = q_item.first_byte ? 1'b0 : odd_r;
    // Odd phase completes a word; an unpaired last byte is padded low
    if (odd_base) begin
      word   = {held_base, q_item.data_val};
      do_add = 1'b1;
    end else begin
      word   = {q_item.data_val, 8'h00};
      do_add = q_item.last_byte;
    end
    sum_acc = do_add ? oc_add(sum_base, word) : sum_base;

    sum_nxt  = sum_r;
    held_nxt = held_r;
    odd_nxt  = odd_r;
    if (take) begin
      if (q_item.last_byte) begin
        sum_nxt  = '0;
        held_nxt = '0;
        odd_nxt  = 1'b0;
      end else begin
        sum_nxt  = sum_acc;
        held_nxt = odd_base ? 8'h00 : q_item.data_val;
        odd_nxt  = !odd_base;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r       <= '0;
      held_r      <= '0;
      odd_r       <= 1'b0;
      res_wr_r    <= '0;
      res_rd_r    <= '0;
      res_count_r <= '0;
    end else begin
      sum_r  <= sum_nxt;
      held_r <= held_nxt;
      odd_r  <= odd_nxt;
      if (res_push) res_wr_r <= res_wr_r + 1'b1;
      if (out_take) res_rd_r <= res_rd_r + 1'b1;
      if (res_push && !out_take)      res_count_r <= res_count_r + 1'b1;
      else if (out_take && !res_push) res_count_r <= res_count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (res_push) res_mem_r[res_wr_r] <= ~sum_acc;
  end

  a_res_bound: assert property (@(posedge clk) disable iff (!rst_n)
    res_count_r <= RES_CNT_W'(RES_DEPTH))
    else $error("back: result queue overflow");

  a_last_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    res_push |=> !out_empty)
    else $error("back: last byte did not leave a result");

endmodule

FILE: bench/ipv6_udp_checksum_engine_core_checker.sv
// Checksum monitor for the IPv6 transport checksum engine: predicts each packet's
// checksum from the accepted byte and register transactions and compares results.
// Depends on icsum_pkg for the register indexes and the index width.
`timescale 1ns / 100ps

module ipv6_udp_checksum_engine_core_checker import icsum_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  input  logic                 in_full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_first_byte,
  input  logic                 in_last_byte,
  input  logic                 in_zero_byte,
  input  logic [63:0]          in_dest_high,
  input  logic [63:0]          in_dest_low,
  input  logic [7:0]           in_packet_length,
  input  logic [7:0]           in_next_header,
  input  logic                 out_empty,
  input  logic                 out_pop,
  input  logic [15:0]          out_checksum,
  input  logic                 cfg_valid,
  input  logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data,
  output int unsigned          mismatches,
  output int unsigned          awaiting
);

  typedef struct packed {
    logic [15:0] sum;
    logic [7:0]  high;
    logic        odd;
  } sum_state_t;

  logic [63:0] own_prefix;
  logic [63:0] own_iid;
  sum_state_t  packet_sum;
  logic [15:0] checksum_q[$];

  function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
    logic [16:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[15:0] + {15'd0, s[16]};
  endfunction

  // Source, destination, then the length and next-header words, in wire order.
  function automatic logic [15:0] pseudo_header_sum(input logic [63:0] dh,
                                                    input logic [63:0] dl,
                                                    input logic [7:0]  len,
                                                    input logic [7:0]  nh);
    logic [255:0] addrs;
    logic [15:0]  acc;
    addrs = {own_prefix, own_iid, dh, dl};
    acc   = '0;
    for (int k = 15; k >= 0; k--) acc = ones_add(acc, addrs[k*16 +: 16]);
    acc = ones_add(acc, {8'h00, len});
    return ones_add(acc, {8'h00, nh});
  endfunction

  always @(posedge clk) begin : track
    logic [7:0]  data;
    logic [15:0] want;
    if (!rst_n) begin
      own_prefix = '0;
      own_iid    = '0;
      packet_sum = '0;
      checksum_q.delete();
      mismatches = 0;
      awaiting   = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SOURCE_PREFIX: own_prefix = cfg_data;
          REG_SOURCE_IID:    own_iid    = cfg_data;
          default: ;
        endcase
      end

      if (in_push && !in_full) begin
        data = in_zero_byte ? 8'h00 : in_data_byte;
        // a first byte drops any partial sum and restarts from the pseudo header
        if (in_first_byte) begin
          packet_sum.sum  = pseudo_header_sum(in_dest_high, in_dest_low,
                                              in_packet_length, in_next_header);
          packet_sum.high = '0;
          packet_sum.odd  = 1'b0;
        end
        if (packet_sum.odd) begin
          packet_sum.sum  = ones_add(packet_sum.sum, {packet_sum.high, data});
          packet_sum.high = '0;
          packet_sum.odd  = 1'b0;
        end else begin
          packet_sum.high = data;
          packet_sum.odd  = 1'b1;
        end
        if (in_last_byte) begin
          // pad a lone final byte with a zero low byte
          if (packet_sum.odd) packet_sum.sum = ones_add(packet_sum.sum, {packet_sum.high, 8'h00});
          checksum_q.push_back(~packet_sum.sum);
          packet_sum = '0;
        end
      end

      if (out_pop && !out_empty) begin
        if (checksum_q.size() == 0) begin
          $error("checksum: no transaction expected, actual 0x%04h", out_checksum);
          mismatches++;
        end else begin
          want = checksum_q.pop_front();
          if (out_checksum !== want) begin
            $error("checksum: expected 0x%04h, actual 0x%04h", want, out_checksum);
            mismatches++;
          end
        end
      end
      awaiting = checksum_q.size();
    end
  end

endmodule

FILE: bench/ipv6_udp_checksum_engine_core_tb.sv
// Top of the checksum engine bench: clock, reset, byte and register stimulus,
// result draining and the verdict. Depends on icsum_pkg, the engine and the monitor.
`timescale 1ns / 100ps

module ipv6_udp_checksum_engine_core_tb;
  import icsum_pkg::*;

  localparam int unsigned HOLD_OFF_CYCLES = 600;
  localparam int unsigned SETTLE_CYCLES   = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 5000;
  localparam int unsigned PHASE_BYTES     = 300;
  localparam int unsigned RANDOM_PHASES   = 5;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LOW  = REG_SOURCE_IID + 1'b1;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HIGH = '1;

  typedef struct packed {
    logic [7:0]  data;
    logic        is_first;
    logic        is_last;
    logic        in_csum;
    logic [63:0] dest_high;
    logic [63:0] dest_low;
    logic [7:0]  pkt_len;
    logic [7:0]  next_hdr;
  } payload_byte_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_push;
  logic                 in_full;
  logic [7:0]           in_data_byte;
  logic                 in_first_byte;
  logic                 in_last_byte;
  logic                 in_zero_byte;
  logic [63:0]          in_dest_high;
  logic [63:0]          in_dest_low;
  logic [7:0]           in_packet_length;
  logic [7:0]           in_next_header;
  logic                 out_empty;
  logic                 out_pop;
  logic [15:0]          out_checksum;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [63:0]          cfg_data;

  int unsigned mismatches;
  int unsigned awaiting;
  int unsigned bytes_sent = 0;
  int unsigned idle_cycles = 0;
  bit          hold_off_req = 1'b0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  ipv6_udp_checksum_engine_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_first_byte(in_first_byte),
    .in_last_byte(in_last_byte), .in_zero_byte(in_zero_byte),
    .in_dest_high(in_dest_high), .in_dest_low(in_dest_low),
    .in_packet_length(in_packet_length), .in_next_header(in_next_header),
    .out_empty(out_empty), .out_pop(out_pop), .out_checksum(out_checksum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  ipv6_udp_checksum_engine_core_checker csum_monitor (
    .clk(clk), .rst_n(rst_n),
    .in_push(in_push), .in_full(in_full),
    .in_data_byte(in_data_byte), .in_first_byte(in_first_byte),
    .in_last_byte(in_last_byte), .in_zero_byte(in_zero_byte),
    .in_dest_high(in_dest_high), .in_dest_low(in_dest_low),
    .in_packet_length(in_packet_length), .in_next_header(in_next_header),
    .out_empty(out_empty), .out_pop(out_pop), .out_checksum(out_checksum),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatches(mismatches), .awaiting(awaiting)
  );

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [63:0] rand_quad();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic payload_byte_t rand_byte();
    payload_byte_t b;
    b.data      = ($urandom_range(0, 9) == 0) ? {8{$urandom_range(0, 1) == 1}}
                                              : 8'($urandom);
    b.is_first  = 1'b0;
    b.is_last   = 1'b0;
    b.in_csum   = 1'b0;
    b.dest_high = rand_quad();
    b.dest_low  = rand_quad();
    b.pkt_len   = 8'($urandom);
    b.next_hdr  = 8'($urandom);
    return b;
  endfunction

  // Call at a falling edge; returns at the falling edge after the byte is accepted, with push still high.
  task automatic push_byte(input payload_byte_t b);
    in_push          <= 1'b1;
    in_data_byte     <= b.data;
    in_first_byte    <= b.is_first;
    in_last_byte     <= b.is_last;
    in_zero_byte     <= b.in_csum;
    in_dest_high     <= b.dest_high;
    in_dest_low      <= b.dest_low;
    in_packet_length <= b.pkt_len;
    in_next_header   <= b.next_hdr;
    @(posedge clk);
    while (in_full) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic push_fields(input logic [7:0] d, input logic f, input logic l, input logic z);
    payload_byte_t b;
    b          = rand_byte();
    b.data     = d;
    b.is_first = f;
    b.is_last  = l;
    b.in_csum  = z;
    push_byte(b);
  endtask

  task automatic pause_input(input int unsigned n);
    if (n > 0) begin
      in_push <= 1'b0;
      repeat (n) @(negedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  // Drain every checksum and let the pipeline empty before touching registers.
  task automatic settle();
    in_push <= 1'b0;
    wait (awaiting == 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic directed_bytes();
    payload_byte_t b;
    b = rand_byte();
    b.data = 8'hFF; b.is_first = 1'b1; b.is_last = 1'b1; b.in_csum = 1'b0;
    b.dest_high = '1; b.dest_low = '1; b.pkt_len = '1; b.next_hdr = '1;
    push_byte(b);
    b.data = 8'h00; b.dest_high = '0; b.dest_low = '0; b.pkt_len = '0; b.next_hdr = '0;
    push_byte(b);
    push_fields(8'hAB, 1'b1, 1'b0, 1'b0);
    push_fields(8'hCD, 1'b0, 1'b1, 1'b0);
    // odd length with a zeroed middle byte
    push_fields(8'h12, 1'b1, 1'b0, 1'b0);
    push_fields(8'hFF, 1'b0, 1'b0, 1'b1);
    push_fields(8'h34, 1'b0, 1'b1, 1'b0);
    // restart on an even and on an odd boundary
    push_fields(8'h55, 1'b1, 1'b0, 1'b0);
    push_fields(8'h66, 1'b0, 1'b0, 1'b0);
    push_fields(8'h77, 1'b1, 1'b0, 1'b0);
    push_fields(8'h88, 1'b0, 1'b1, 1'b0);
    push_fields(8'h01, 1'b1, 1'b0, 1'b0);
    push_fields(8'h02, 1'b1, 1'b0, 1'b0);
    push_fields(8'h03, 1'b0, 1'b1, 1'b0);
    // bytes without a first byte sum with no pseudo header
    push_fields(8'hF0, 1'b0, 1'b0, 1'b0);
    push_fields(8'h0F, 1'b0, 1'b0, 1'b0);
    push_fields(8'hFF, 1'b0, 1'b1, 1'b0);
    push_fields(8'h80, 1'b0, 1'b1, 1'b0);
    push_fields(8'hFF, 1'b1, 1'b0, 1'b1);
    push_fields(8'hFF, 1'b0, 1'b0, 1'b1);
    push_fields(8'hFF, 1'b0, 1'b1, 1'b0);
    push_fields(8'hFF, 1'b1, 1'b1, 1'b1);
  endtask

  // Mostly well-formed packets; a few are orphaned, restarted, cut short or split.
  task automatic send_packet(input bit steady);
    payload_byte_t b;
    int unsigned   kind;
    int unsigned   n;
    bit            has_csum;
    kind     = $urandom_range(0, 99);
    n        = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 65) : $urandom_range(1, 13);
    has_csum = ($urandom_range(0, 1) == 1) && (n > 7);
    for (int unsigned i = 0; i < n; i++) begin
      b          = rand_byte();
      b.is_first = (i == 0) && !(kind < 6);
      b.is_last  = (i == n - 1) && !(kind >= 12 && kind < 16);
      if (kind >= 6 && kind < 12 && n > 2 && i == n / 2) b.is_first = 1'b1;
      if (kind >= 16 && kind < 19 && i == n / 2) b.is_last = 1'b1;
      b.in_csum  = (has_csum && (i == 6 || i == 7)) || ($urandom_range(0, 19) == 0);
      if (i == 0 && $urandom_range(0, 1) == 1) b.pkt_len = 8'(n);
      push_byte(b);
      if (!steady) pause_input(gap_len());
    end
  endtask

  task automatic close_packet();
    payload_byte_t b;
    b          = rand_byte();
    b.is_first = 1'b1;
    b.is_last  = 1'b1;
    push_byte(b);
  endtask

  // Result side: bursts of pops, random gaps and one long hold-off on request.
  initial begin : drain
    int unsigned n;
    bit          held_off;
    held_off = 1'b0;
    out_pop  = 1'b0;
    wait (rst_n);
    @(negedge clk);
    forever begin
      if (hold_off_req && !held_off) begin
        held_off = 1'b1;
        out_pop <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(negedge clk);
      end else begin
        out_pop <= 1'b1;
        repeat ($urandom_range(1, 40)) @(negedge clk);
        n = gap_len();
        if (n > 0) begin
          out_pop <= 1'b0;
          repeat (n) @(negedge clk);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_push && !in_full) || (out_pop && !out_empty) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("ipv6_udp_checksum_engine_core verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int unsigned target;
    rst_n            = 1'b0;
    in_push          = 1'b0;
    in_data_byte     = '0;
    in_first_byte    = 1'b0;
    in_last_byte     = 1'b0;
    in_zero_byte     = 1'b0;
    in_dest_high     = '0;
    in_dest_low      = '0;
    in_packet_length = '0;
    in_next_header   = '0;
    cfg_valid        = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    write_reg(REG_SOURCE_PREFIX, '0);
    write_reg(REG_SOURCE_IID, '0);
    directed_bytes();
    settle();

    for (int unsigned phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: begin
          write_reg(REG_SOURCE_PREFIX, '1);
          write_reg(REG_SOURCE_IID, '1);
        end
        1: begin
          write_reg(REG_SOURCE_PREFIX, {$urandom, $urandom});
          write_reg(REG_UNMAPPED_LOW, {$urandom, $urandom});
          write_reg(REG_SOURCE_IID, {$urandom, $urandom});
          write_reg(REG_UNMAPPED_HIGH, '1);
        end
        2: begin
          write_reg(REG_SOURCE_PREFIX, '1);
          write_reg(REG_SOURCE_IID, '0);
        end
        3: begin
          write_reg(REG_SOURCE_PREFIX, 64'h8000_0000_0000_0001);
          write_reg(REG_SOURCE_IID, 64'hFFFF_0000_FFFF_0000);
        end
        default: begin
          write_reg(REG_SOURCE_PREFIX, {$urandom, $urandom});
          write_reg(REG_SOURCE_IID, {$urandom, $urandom});
        end
      endcase
      // hold the result side off once while bytes keep coming
      if (phase == 0) hold_off_req = 1'b1;
      target = bytes_sent + PHASE_BYTES;
      while (bytes_sent < target) send_packet($urandom_range(0, 3) == 0);
      close_packet();
      settle();
    end

    wait (awaiting == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("ipv6_udp_checksum_engine_core verification clean");
    end else begin
      $display("ipv6_udp_checksum_engine_core verification failed");
    end
    $finish;
  end

endmodule

FILE: filelist.f
src/icsum_pkg.sv
src/icsum_front.sv
src/icsum_queue.sv
src/icsum_back.sv
src/ipv6_udp_checksum_engine_core.sv
bench/ipv6_udp_checksum_engine_core_checker.sv
bench/ipv6_udp_checksum_engine_core_tb.sv
